// File: hdl/assert_macros.svh
// Assertion macros used by the verification checker of the framer.
// Depends on nothing; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MWRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MWRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`endif

// File: hdl/mwrf_pkg.sv
// Shared constants, status types and the CRC-16/Modbus byte step of the framer.
// Depends on nothing; used by mwrf_tx, mwrf_rx, the top level and the testbench.
`default_nettype none

package mwrf_pkg;

	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
	localparam logic        KIND_SEND       = 1'b0;
	localparam logic        KIND_RX_BYTE    = 1'b1;
	localparam logic        RES_TX_BYTE     = 1'b0;
	localparam logic        RES_VERDICT     = 1'b1;
	localparam logic [2:0]  IDX_CRC_LO      = 3'd6;
	localparam logic [2:0]  IDX_CRC_HI      = 3'd7;

	typedef struct packed {
		logic       busy;
		logic [7:0] tx_byte;
		logic       last;
	} tx_stat_t;

	typedef struct packed {
		logic verdict;
		logic echo_ok;
	} rx_stat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/mwrf_cmd_if.sv
// Input channel of the framer: valid/ready handshake with the request payload.
// Depends on nothing.
`default_nettype none

interface mwrf_cmd_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  device_address;
	logic [15:0] register_address;
	logic [15:0] register_value;
	logic [7:0]  rx_byte;

	modport source (output valid, kind, device_address, register_address, register_value,
		rx_byte, input ready);
	modport sink (input valid, kind, device_address, register_address, register_value,
		rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/mwrf_res_if.sv
// Result channel of the framer: valid/ready handshake with the result payload.
// Depends on nothing.
`default_nettype none

interface mwrf_res_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] tx_byte;
	logic       last;
	logic       echo_ok;

	modport source (output valid, result_kind, tx_byte, last, echo_ok, input ready);
	modport sink (input valid, result_kind, tx_byte, last, echo_ok, output ready);
endinterface

`default_nettype wire

// File: hdl/mwrf_tx.sv
// Request serializer: holds the kept frame and emits it one byte per step with the CRC.
// Depends on mwrf_pkg.
`default_nettype none

module mwrf_tx (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [7:0]          device_address,
	input  wire logic [15:0]         register_address,
	input  wire logic [15:0]         register_value,
	input  wire logic                advance,
	output mwrf_pkg::tx_stat_t       stat,
	output logic      [63:0]         frame
);

	logic [63:0] frame_q;
	logic [15:0] crc_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic [7:0]  cur_byte;

	always_comb begin
		cur_byte = frame_q[{cnt_q, 3'b000} +: 8];
		if (cnt_q == mwrf_pkg::IDX_CRC_LO) begin
			cur_byte = crc_q[7:0];
		end else if (cnt_q == mwrf_pkg::IDX_CRC_HI) begin
			cur_byte = crc_q[15:8];
		end
	end

	assign stat.busy    = busy_q;
	assign stat.tx_byte = cur_byte;
	assign stat.last    = (cnt_q == mwrf_pkg::IDX_CRC_HI);
	assign frame        = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			crc_q   <= mwrf_pkg::CRC_INIT;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else if (start) begin
			frame_q <= {16'h0000, register_value[7:0], register_value[15:8],
				register_address[7:0], register_address[15:8],
				mwrf_pkg::FN_WRITE_SINGLE, device_address};
			crc_q   <= mwrf_pkg::CRC_INIT;
			cnt_q   <= '0;
			busy_q  <= 1'b1;
		end else if (busy_q && advance) begin
			if (cnt_q < mwrf_pkg::IDX_CRC_LO) begin
				crc_q <= mwrf_pkg::crc_byte(crc_q, cur_byte);
			end
			if (cnt_q == mwrf_pkg::IDX_CRC_LO) begin
				frame_q[63:48] <= crc_q;
			end
			if (cnt_q == mwrf_pkg::IDX_CRC_HI) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

// File: hdl/mwrf_rx.sv
// Response checker: runs the CRC over the response and compares it with the kept frame.
// Depends on mwrf_pkg.
`default_nettype none

module mwrf_rx (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           clear,
	input  wire logic           take,
	input  wire logic [7:0]     rx_byte,
	input  wire logic [63:0]    frame,
	output mwrf_pkg::rx_stat_t  stat
);

	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        mis_q;
	logic [7:0]  crc_lo_q;
	logic [7:0]  expect_byte;
	logic        mis_now;
	logic        verdict;

	assign expect_byte  = frame[{idx_q, 3'b000} +: 8];
	assign mis_now      = mis_q | (rx_byte != expect_byte);
	assign verdict      = take && (idx_q == mwrf_pkg::IDX_CRC_HI);
	assign stat.verdict = verdict;
	assign stat.echo_ok = !mis_now && (crc_q == {rx_byte, crc_lo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			crc_q    <= mwrf_pkg::CRC_INIT;
			mis_q    <= 1'b0;
			crc_lo_q <= '0;
		end else if (clear || verdict) begin
			idx_q    <= '0;
			crc_q    <= mwrf_pkg::CRC_INIT;
			mis_q    <= 1'b0;
			crc_lo_q <= '0;
		end else if (take) begin
			mis_q <= mis_now;
			if (idx_q < mwrf_pkg::IDX_CRC_LO) begin
				crc_q <= mwrf_pkg::crc_byte(crc_q, rx_byte);
			end
			if (idx_q == mwrf_pkg::IDX_CRC_LO) begin
				crc_lo_q <= rx_byte;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

// File: hdl/modbus_write_register_framer_top.sv
// Top level of the Modbus RTU write-single-register framer with response echo check.
// Depends on mwrf_pkg, mwrf_cmd_if, mwrf_res_if, mwrf_tx and mwrf_rx.
//
// A send item loads the request, then the byte-wide serializer emits eight transmit
// bytes at one per cycle while the sink takes them, its CRC advancing one byte a
// cycle over the six data bytes; no item is taken while it runs. A response byte is
// taken in one handshake, and the eighth one puts its verdict in the output register
// at the edge that takes it. The output register holds a result while the sink stalls,
// and no item is taken while a result waits there. It reloads in the cycle its result
// is taken, so with a sink that is always ready, response bytes follow back to back.
`default_nettype none

module modbus_write_register_framer_top (
	input wire logic   clk,
	input wire logic   arst_n,
	mwrf_cmd_if.sink   cmd,
	mwrf_res_if.source res
);

	mwrf_pkg::tx_stat_t tx_stat;
	mwrf_pkg::rx_stat_t rx_stat;
	logic [63:0]        frame;
	logic               o_load;
	logic               accept;
	logic               send;
	logic               take;

	logic       o_valid_q;
	logic       o_kind_q;
	logic [7:0] o_byte_q;
	logic       o_last_q;
	logic       o_ok_q;

	assign o_load    = !o_valid_q || res.ready;
	assign cmd.ready = !tx_stat.busy && o_load;
	assign accept    = cmd.valid && cmd.ready;
	assign send      = accept && (cmd.kind == mwrf_pkg::KIND_SEND);
	assign take      = accept && (cmd.kind == mwrf_pkg::KIND_RX_BYTE);

	mwrf_tx u_tx (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (send),
		.device_address   (cmd.device_address),
		.register_address (cmd.register_address),
		.register_value   (cmd.register_value),
		.advance          (o_load),
		.stat             (tx_stat),
		.frame            (frame)
	);

	mwrf_rx u_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (send),
		.take    (take),
		.rx_byte (cmd.rx_byte),
		.frame   (frame),
		.stat    (rx_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (o_load) begin
			o_valid_q <= tx_stat.busy || rx_stat.verdict;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			if (tx_stat.busy) begin
				o_kind_q <= mwrf_pkg::RES_TX_BYTE;
				o_byte_q <= tx_stat.tx_byte;
				o_last_q <= tx_stat.last;
				o_ok_q   <= 1'b0;
			end else begin
				o_kind_q <= mwrf_pkg::RES_VERDICT;
				o_byte_q <= 8'h00;
				o_last_q <= 1'b1;
				o_ok_q   <= rx_stat.echo_ok;
			end
		end
	end

	assign res.valid       = o_valid_q;
	assign res.result_kind = o_kind_q;
	assign res.tx_byte     = o_byte_q;
	assign res.last        = o_last_q;
	assign res.echo_ok     = o_ok_q;

endmodule

`default_nettype wire

// File: hdl/mwrf_checker.sv
// Port-level checker for the framer, bound to the top level.
// Depends on assert_macros.svh and modbus_write_register_framer_top.
`default_nettype none
`include "assert_macros.svh"

module mwrf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_valid,
	input wire logic       cmd_ready,
	input wire logic       cmd_kind,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       res_result_kind,
	input wire logic [7:0] res_tx_byte,
	input wire logic       res_last,
	input wire logic       res_echo_ok
);

	`MWRF_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(res_result_kind) && $stable(res_tx_byte) && $stable(res_last) && $stable(res_echo_ok))
	`MWRF_ASSERT_IMP(a_verdict_form, clk, arst_n, res_valid && res_result_kind,
		res_last && (res_tx_byte == 8'h00))
	`MWRF_ASSERT_IMP(a_tx_no_ok, clk, arst_n, res_valid && !res_result_kind, !res_echo_ok)
	`MWRF_ASSERT_NXT(a_send_busy, clk, arst_n, cmd_valid && cmd_ready && !cmd_kind, !cmd_ready)

endmodule

bind modbus_write_register_framer_top mwrf_checker u_mwrf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.cmd_kind        (cmd.kind),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_result_kind (res.result_kind),
	.res_tx_byte     (res.tx_byte),
	.res_last        (res.last),
	.res_echo_ok     (res.echo_ok)
);

`default_nettype wire

// File: tb/tb_modbus_write_register_framer_top.sv
`timescale 1ns / 1ps
// Testbench for the Modbus RTU write-single-register framer: directed and random
// requests and response bytes, checked against an in-bench model of the frame and echo check.
// Depends on mwrf_pkg, mwrf_cmd_if, mwrf_res_if and modbus_write_register_framer_top.

module tb_modbus_write_register_framer_top;

	typedef struct packed {
		logic        kind;
		logic [7:0]  dev_addr;
		logic [15:0] reg_addr;
		logic [15:0] reg_value;
		logic [7:0]  rx_byte;
	} framer_cmd_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] tx_byte;
		logic       last;
		logic       echo_ok;
	} framer_result_t;

	logic clk;
	logic arst_n;

	mwrf_cmd_if cmd_ch ();
	mwrf_res_if res_ch ();

	modbus_write_register_framer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	framer_result_t pending_frame_results[$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	logic [63:0] kept_frame = '0;
	logic [2:0]  echo_pos = '0;
	logic [15:0] echo_crc = mwrf_pkg::CRC_INIT;
	logic        echo_differs = 1'b0;
	logic [15:0] echo_crc_field = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
		input logic [7:0] data);
		logic [15:0] acc;
		logic        fb;
		acc = crc;
		for (int i = 0; i < 8; i++) begin
			fb = acc[0] ^ data[i];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ mwrf_pkg::CRC_POLY;
			end
		end
		return acc;
	endfunction

	function automatic void clear_echo_check();
		echo_pos = '0;
		echo_crc = mwrf_pkg::CRC_INIT;
		echo_differs = 1'b0;
		echo_crc_field = '0;
	endfunction

	function automatic void expect_result(input framer_result_t r);
		pending_frame_results = {pending_frame_results, r};
	endfunction

	function automatic void predict_framer(input framer_cmd_t c);
		logic [7:0]     frame_bytes[8];
		logic [15:0]    crc;
		framer_result_t r;
		if (c.kind == mwrf_pkg::KIND_SEND) begin
			frame_bytes[0] = c.dev_addr;
			frame_bytes[1] = mwrf_pkg::FN_WRITE_SINGLE;
			frame_bytes[2] = c.reg_addr[15:8];
			frame_bytes[3] = c.reg_addr[7:0];
			frame_bytes[4] = c.reg_value[15:8];
			frame_bytes[5] = c.reg_value[7:0];
			crc = mwrf_pkg::CRC_INIT;
			for (int i = 0; i < 6; i++) begin
				crc = crc16_modbus_step(crc, frame_bytes[i]);
			end
			frame_bytes[6] = crc[7:0];
			frame_bytes[7] = crc[15:8];
			for (int i = 0; i < 8; i++) begin
				kept_frame[8*i +: 8] = frame_bytes[i];
				r.result_kind = mwrf_pkg::RES_TX_BYTE;
				r.tx_byte = frame_bytes[i];
				r.last = (i == 7);
				r.echo_ok = 1'b0;
				expect_result(r);
			end
			clear_echo_check();
		end else begin
			if (c.rx_byte != kept_frame[8*echo_pos +: 8]) begin
				echo_differs = 1'b1;
			end
			if (echo_pos < mwrf_pkg::IDX_CRC_LO) begin
				echo_crc = crc16_modbus_step(echo_crc, c.rx_byte);
			end else if (echo_pos == mwrf_pkg::IDX_CRC_LO) begin
				echo_crc_field[7:0] = c.rx_byte;
			end else begin
				echo_crc_field[15:8] = c.rx_byte;
			end
			if (echo_pos == mwrf_pkg::IDX_CRC_HI) begin
				r.result_kind = mwrf_pkg::RES_VERDICT;
				r.tx_byte = 8'h00;
				r.last = 1'b1;
				r.echo_ok = !echo_differs && (echo_crc == echo_crc_field);
				expect_result(r);
				clear_echo_check();
			end else begin
				echo_pos = echo_pos + 3'd1;
			end
		end
	endfunction

	function automatic void note_failure(input string what, input framer_result_t want,
		input framer_result_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s: expected kind=%0d byte=%02h last=%0d ok=%0d,",
				$realtime, what, want.result_kind, want.tx_byte, want.last, want.echo_ok,
				" got kind=%0d byte=%02h last=%0d ok=%0d",
				got.result_kind, got.tx_byte, got.last, got.echo_ok);
		end
	endfunction

	always @(posedge clk) begin
		framer_result_t got;
		framer_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.result_kind = res_ch.result_kind;
			got.tx_byte = res_ch.tx_byte;
			got.last = res_ch.last;
			got.echo_ok = res_ch.echo_ok;
			if (pending_frame_results.size() == 0) begin
				note_failure("unexpected result", 'x, got);
			end else begin
				want = pending_frame_results.pop_front();
				if (got.result_kind !== want.result_kind || got.tx_byte !== want.tx_byte ||
					got.last !== want.last || got.echo_ok !== want.echo_ok) begin
					note_failure("result mismatch", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic framer_cmd_t make_request(input logic [7:0] dev,
		input logic [15:0] reg_addr, input logic [15:0] reg_value);
		framer_cmd_t c;
		c.kind = mwrf_pkg::KIND_SEND;
		c.dev_addr = dev;
		c.reg_addr = reg_addr;
		c.reg_value = reg_value;
		c.rx_byte = 8'($urandom_range(255));
		return c;
	endfunction

	function automatic framer_cmd_t make_rx(input logic [7:0] b);
		framer_cmd_t c;
		c.kind = mwrf_pkg::KIND_RX_BYTE;
		c.dev_addr = 8'($urandom_range(255));
		c.reg_addr = 16'($urandom_range(65535));
		c.reg_value = 16'($urandom_range(65535));
		c.rx_byte = b;
		return c;
	endfunction

	task automatic send_item(input framer_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= c.kind;
		cmd_ch.device_address <= c.dev_addr;
		cmd_ch.register_address <= c.reg_addr;
		cmd_ch.register_value <= c.reg_value;
		cmd_ch.rx_byte <= c.rx_byte;
		do begin
			@(posedge clk);
		end while (!cmd_ch.ready);
		predict_framer(c);
	endtask

	task automatic send_random_request();
		send_item(make_request(8'($urandom_range(255)), 16'($urandom_range(65535)),
			16'($urandom_range(65535))));
	endtask

	// Sends the first n bytes of the kept frame, with the byte at bad_pos flipped when 0 <= bad_pos < n.
	task automatic send_echo(input int n, input int bad_pos);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = kept_frame[8*i +: 8];
			if (i == bad_pos) begin
				b = b ^ 8'($urandom_range(1, 255));
			end
			send_item(make_rx(b));
		end
	endtask

	task automatic wait_for_results();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_frame_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_response_before_request();
		for (int i = 0; i < 8; i++) begin
			send_item(make_rx(8'h00));
		end
		wait_for_results();
	endtask

	task automatic test_request_extremes();
		send_item(make_request(8'h00, 16'h0000, 16'h0000));
		send_echo(3, -1);
		send_item(make_request(8'hFF, 16'hFFFF, 16'hFFFF));
		send_echo(8, -1);
		wait_for_results();
	endtask

	task automatic test_output_stall();
		hold_cycles <= 200;
		send_random_request();
		send_echo(8, -1);
		send_random_request();
		send_echo(8, $urandom_range(7));
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
		input int n_items);
		int sent;
		int pick;
		int cut;
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_random_request();
				send_echo(8, ($urandom_range(99) < 30) ? int'($urandom_range(7)) : -1);
				sent += 9;
			end else if (pick < 70) begin
				send_echo(8, ($urandom_range(99) < 30) ? int'($urandom_range(7)) : -1);
				sent += 8;
			end else if (pick < 85) begin
				cut = $urandom_range(1, 7);
				send_echo(cut, -1);
				sent += cut;
			end else begin
				cut = $urandom_range(1, 8);
				for (int i = 0; i < cut; i++) begin
					send_item(make_rx(8'($urandom_range(255))));
				end
				sent += cut;
			end
		end
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = mwrf_pkg::KIND_SEND;
		cmd_ch.device_address = '0;
		cmd_ch.register_address = '0;
		cmd_ch.register_value = '0;
		cmd_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_response_before_request();
		test_request_extremes();
		test_output_stall();
		test_random_traffic(20, 87, 170);
		test_random_traffic(87, 20, 170);
		test_random_traffic(0, 0, 170);

		repeat (30) @(posedge clk);
		if (pending_frame_results.size() != 0) begin
			note_failure("result never arrived", pending_frame_results[0], 'x);
		end
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
